### sv/hec_pkg.sv
// shared types, character codes and entity tables for the html entity codec
// no dependencies; imported by hec_codec and html_entity_codec_top
package hec_pkg;

	localparam int RUN_MAX = 5;

	// entity entries
	localparam logic [1:0] ENT_AMP = 2'd0;
	localparam logic [1:0] ENT_GT  = 2'd1;
	localparam logic [1:0] ENT_LT  = 2'd2;

	// character codes
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_LT   = 8'h3c;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_M    = 8'h6d;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_G    = 8'h67;
	localparam logic [7:0] CH_L    = 8'h6c;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_SEMI = 8'h3b;

	// decode match state
	typedef struct packed {
		logic [1:0] entry;
		logic [2:0] count;
	} match_t;

	// run of result bytes caused by one request
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [2:0]              count;
	} run_t;

	// entity text by entry and position
	function automatic logic [7:0] ent_text(logic [1:0] e, logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		unique case (e)
			ENT_AMP: begin
				unique case (i)
					3'd0: r = CH_AMP;
					3'd1: r = CH_A;
					3'd2: r = CH_M;
					3'd3: r = CH_P;
					3'd4: r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			ENT_GT: begin
				unique case (i)
					3'd0: r = CH_AMP;
					3'd1: r = CH_G;
					3'd2: r = CH_T;
					3'd3: r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			ENT_LT: begin
				unique case (i)
					3'd0: r = CH_AMP;
					3'd1: r = CH_L;
					3'd2: r = CH_T;
					3'd3: r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// entity length; zero for the unused entry so it reads as idle
	function automatic logic [2:0] ent_len(logic [1:0] e);
		logic [2:0] r;
		unique case (e)
			ENT_AMP: r = 3'd5;
			ENT_GT:  r = 3'd4;
			ENT_LT:  r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// decoded character of an entity
	function automatic logic [7:0] ent_char(logic [1:0] e);
		logic [7:0] r;
		unique case (e)
			ENT_AMP: r = CH_AMP;
			ENT_GT:  r = CH_GT;
			ENT_LT:  r = CH_LT;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### sv/html_entity_codec_top.sv
// a request is taken into the input register, and its result run, if any, then into the run buffer
// throughput: one result byte per cycle while out_stall is low; a request that yields no bytes
// never stalls the input, one that yields bytes waits until the buffer is empty or shows its last
// byte with out_stall low; the five-byte run buffer drain sets the rate; arst_n clears direction
// (encode), the match state and all valid flags
module html_entity_codec_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import hec_pkg::*;

	logic                    direction_q;
	match_t                  match_q;
	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic [RUN_MAX-1:0][7:0] run_byte_q;
	logic [2:0]              run_rem_q;
	run_t                    run;
	match_t                  match_next;
	logic                    run_free;
	logic                    s1_move;
	logic                    pop;
	logic                    cfg_write;
	logic                    in_take;

	// step logic on the input register
	hec_codec u_codec (
		.direction  (direction_q),
		.in_byte    (byte_s1),
		.match      (match_q),
		.run        (run),
		.match_next (match_next)
	);

	// handshake
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;
	assign pop       = out_valid & ~out_stall;
	assign run_free  = (run_rem_q == 3'd0) || (run_rem_q == 3'd1 && !out_stall);
	assign s1_move   = valid_s1 & (run_free | (run.count == 3'd0));
	assign in_stall  = valid_s1 & ~s1_move;
	assign in_take   = in_valid & ~in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	// direction register and match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			match_q     <= '0;
		end else if (cfg_write) begin
			direction_q <= cfg_data;
			match_q     <= '0;
		end else if (s1_move) begin
			match_q <= match_next;
		end
	end

	// run buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_rem_q <= 3'd0;
		end else if (s1_move && run.count != 3'd0) begin
			run_rem_q <= run.count;
		end else if (pop) begin
			run_rem_q <= run_rem_q - 3'd1;
		end
	end

	// run buffer bytes, shifted out from the bottom
	always_ff @(posedge clk) begin
		if (s1_move && run.count != 3'd0) begin
			run_byte_q <= run.bytes;
		end else if (pop) begin
			run_byte_q <= {8'h00, run_byte_q[RUN_MAX-1:1]};
		end
	end

	// result port
	assign out_valid = (run_rem_q != 3'd0);
	assign out_byte  = run_byte_q[0];
	assign run_last  = (run_rem_q == 3'd1);

	// checks
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_rem_q <= 3'(RUN_MAX))
		else $error("run buffer count beyond run size");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && run.count != 3'd0) |=> out_valid)
		else $error("loaded run not presented");

	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		match_q.count < 3'(RUN_MAX))
		else $error("match count reached entity length");

	a_encode_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && !direction_q && !cfg_write) |=> $stable(match_q))
		else $error("encode changed match state");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && run.count != 3'd0))
		else $error("input stalled with nothing to drain");

endmodule

### sv/hec_codec.sv
// single-pass step logic: one text byte plus match state in, result run and next state out
// depends on hec_pkg
module hec_codec (
	input  logic            direction,
	input  logic [7:0]      in_byte,
	input  hec_pkg::match_t match,
	output hec_pkg::run_t   run,
	output hec_pkg::match_t match_next
);
	import hec_pkg::*;

	logic [1:0] e;
	logic [2:0] k;

	always_comb begin
		run        = '0;
		match_next = match;
		e          = match.entry;
		k          = match.count;
		if (!direction) begin
			// encode: special characters expand to their entity
			priority if (in_byte == CH_AMP) begin
				e = ENT_AMP;
			end else if (in_byte == CH_GT) begin
				e = ENT_GT;
			end else if (in_byte == CH_LT) begin
				e = ENT_LT;
			end else begin
				e = 2'd3;
			end
			if (e != 2'd3) begin
				for (int i = 0; i < RUN_MAX; i++) begin
					run.bytes[i] = ent_text(e, 3'(i));
				end
				run.count = ent_len(e);
			end else begin
				run.bytes[0] = in_byte;
				run.count    = 3'd1;
			end
		end else begin
			// decode: out-of-range state counts as idle
			if (k >= ent_len(e)) begin
				k = 3'd0;
			end
			if (k == 3'd0) begin
				match_next.entry = ENT_AMP;
				if (in_byte == CH_AMP) begin
					match_next.count = 3'd1;
				end else begin
					match_next.count = 3'd0;
					run.bytes[0]     = in_byte;
					run.count        = 3'd1;
				end
			end else begin
				// after the leading ampersand the match may move to another entity
				if (in_byte != ent_text(e, k) && k == 3'd1) begin
					priority if (in_byte == ent_text(ENT_AMP, 3'd1)) begin
						e = ENT_AMP;
					end else if (in_byte == ent_text(ENT_GT, 3'd1)) begin
						e = ENT_GT;
					end else if (in_byte == ent_text(ENT_LT, 3'd1)) begin
						e = ENT_LT;
					end else begin
						e = e;
					end
				end
				if (in_byte == ent_text(e, k)) begin
					if (k + 3'd1 == ent_len(e)) begin
						match_next   = '0;
						run.bytes[0] = ent_char(e);
						run.count    = 3'd1;
					end else begin
						match_next.entry = e;
						match_next.count = k + 3'd1;
					end
				end else begin
					// mismatch: held prefix, then the byte again from idle
					for (int i = 0; i < RUN_MAX; i++) begin
						if (3'(i) < k) begin
							run.bytes[i] = ent_text(e, 3'(i));
						end else if (3'(i) == k) begin
							run.bytes[i] = in_byte;
						end
					end
					match_next.entry = ENT_AMP;
					if (in_byte == CH_AMP) begin
						match_next.count = 3'd1;
						run.count        = k;
					end else begin
						match_next.count = 3'd0;
						run.count        = k + 3'd1;
					end
				end
			end
		end
	end

endmodule
